### design/nco_pkg.sv
package nco_pkg;

    localparam int NUM_OSC      = 4;
    localparam int NUM_DETUNED  = 3;
    localparam int DETUNE_STEPS = 49;
    localparam int IDX_W        = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    localparam int SET_W     = 29;
    localparam int PPH_W     = 40;
    localparam int BASE_W    = 22;
    localparam int FREQ_W    = 26;
    localparam int PHASE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 40;
    localparam int SAMPLE_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_PER_HZ = 3'd4;

    localparam logic [SET_W-1:0] SET_RESET     = 29'd3072;
    localparam logic [SET_W-1:0] SET_RESET_SUB = 29'd3192;
    localparam logic [PPH_W-1:0] PPH_RESET     = 40'd5864062014;

    localparam logic [BASE_W-1:0] BASE_MIN = 22'd5120;
    localparam logic [BASE_W-1:0] BASE_MAX = 22'd4096000;
    localparam logic [30:0]       FREQ_MIN = 31'd81920;
    localparam logic [30:0]       FREQ_MAX = 31'd65536000;
    localparam logic [15:0]       MIX_ONE  = 16'd32768;
    localparam logic [16:0]       GAIN_ONE = 17'd65536;

    localparam logic [2:0] WAVE_SINE   = 3'd1;
    localparam logic [2:0] WAVE_SQUARE = 3'd2;
    localparam logic [2:0] WAVE_TRI    = 3'd3;
    localparam logic [2:0] WAVE_SAW    = 3'd4;

    localparam logic [16:0] DETUNE_TABLE [0:DETUNE_STEPS-1] = '{
        17'd64634, 17'd64671, 17'd64709, 17'd64746, 17'd64783, 17'd64821, 17'd64858,
        17'd64896, 17'd64934, 17'd64971, 17'd65009, 17'd65047, 17'd65084, 17'd65122,
        17'd65160, 17'd65198, 17'd65236, 17'd65274, 17'd65311, 17'd65349, 17'd65387,
        17'd65425, 17'd65464, 17'd65502, 17'd65536, 17'd65574, 17'd65612, 17'd65650,
        17'd65688, 17'd65726, 17'd65764, 17'd65802, 17'd65840, 17'd65878, 17'd65916,
        17'd65954, 17'd65993, 17'd66031, 17'd66069, 17'd66108, 17'd66146, 17'd66184,
        17'd66223, 17'd66261, 17'd66300, 17'd66339, 17'd66377, 17'd66416, 17'd66455
    };

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_NOTE_ON,
        OP_CACHE_SET,
        OP_FREQ_MUL,
        OP_FREQ_CLAMP,
        OP_LO_MUL,
        OP_HI_MUL,
        OP_INC_WR,
        OP_WAVE_MUL,
        OP_ACC,
        OP_GAIN_MUL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic             div_first;
    } cmd_t;

    typedef struct packed {
        logic               gain_dirty;
        logic               func;
        logic               any_active;
        logic               need_update;
        logic               out_free;
        logic [NUM_OSC-1:0] mask;
    } status_t;

    function automatic logic [16:0] detune_factor(input logic [5:0] code);
        logic [5:0] i;
        i = (code > 6'(DETUNE_STEPS - 1)) ? 6'(DETUNE_STEPS - 1) : code;
        return DETUNE_TABLE[i];
    endfunction

endpackage

### design/nco_if.sv
interface nco_req_if;
    import nco_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BASE_W-1:0] base_freq;
    modport source (output valid, output func, output base_freq, input ready);
    modport sink   (input valid, input func, input base_freq, output ready);
endinterface

interface nco_rsp_if;
    import nco_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### design/nco_oscillator_bank_mixer_core.sv
// Channel   Role    Beat contents
// request   sink    func, base_freq
// response  source  sample
// cfg       write   cfg_we, cfg_index, cfg_data
//
// A note-on beat clears the phases and the frequency cache. A sample beat with nothing
// active emits zero; otherwise the increments are first recomputed when the base
// frequency, the settings or the phase-per-Hz value changed, or after a note-on,
// and all products go through one shared multiplier.
// A settings write holds request off while a serial divide forms the mix gain; a
// write during the divide starts it again. Reset clears phases, increments and the
// cache.
// The finished sample waits in the output register while response is stalled.
module nco_oscillator_bank_mixer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    nco_req_if.sink                        request,
    nco_rsp_if.source                      response,
    input  logic                           cfg_we,
    input  logic [nco_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nco_pkg::CFG_W-1:0]      cfg_data
);
    import nco_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign request.ready = in_ready;

    nco_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd)
    );

    nco_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (request.valid && in_ready),
        .in_func      (request.func),
        .in_base_freq (request.base_freq),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (response.ready),
        .out_valid    (response.valid),
        .out_sample   (response.sample)
    );

endmodule

### design/nco_ctrl.sv
module nco_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cfg_we,
    input  nco_pkg::status_t status,
    output nco_pkg::cmd_t    cmd
);
    import nco_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_INIT, S_DIV_STEP, S_DIV_FIN, S_DISPATCH,
        S_FREQ_MUL, S_FREQ_CLAMP, S_LO_MUL, S_HI_MUL, S_INC_WR,
        S_WAVE_MUL, S_ACC, S_GAIN_MUL, S_EMIT
    } state_t;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_OSC - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [4:0]       cnt_reg;
    logic             idx_active;
    logic             idx_last;

    assign idx_active = status.mask[idx_reg];
    assign idx_last   = (idx_reg == IDX_LAST);
    assign in_ready   = (state_reg == S_IDLE) && !status.gain_dirty && !cfg_we;

    always_comb
    begin
        cmd.idx       = idx_reg;
        cmd.div_first = (cnt_reg == 5'd0);
        cmd.op        = OP_NONE;
        unique case (state_reg)
            S_IDLE:       cmd.op = OP_NONE;
            S_DIV_INIT:   cmd.op = OP_DIV_INIT;
            S_DIV_STEP:   cmd.op = OP_DIV_STEP;
            S_DIV_FIN:    cmd.op = OP_DIV_FIN;
            S_DISPATCH:
            begin
                if (status.func)
                    cmd.op = OP_NOTE_ON;
                else if (status.any_active && status.need_update)
                    cmd.op = OP_CACHE_SET;
            end
            S_FREQ_MUL:   cmd.op = idx_active ? OP_FREQ_MUL : OP_NONE;
            S_FREQ_CLAMP: cmd.op = OP_FREQ_CLAMP;
            S_LO_MUL:     cmd.op = OP_LO_MUL;
            S_HI_MUL:     cmd.op = OP_HI_MUL;
            S_INC_WR:     cmd.op = OP_INC_WR;
            S_WAVE_MUL:   cmd.op = idx_active ? OP_WAVE_MUL : OP_NONE;
            S_ACC:        cmd.op = OP_ACC;
            S_GAIN_MUL:   cmd.op = OP_GAIN_MUL;
            S_EMIT:       cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_valid && in_ready)
                        state_reg <= S_DISPATCH;
                    else if (status.gain_dirty && !cfg_we)
                        state_reg <= S_DIV_INIT;
                end
                // A register write during the divide abandons it; the gain
                // stays dirty and the divide starts again from idle.
                S_DIV_INIT:
                begin
                    cnt_reg <= '0;
                    if (cfg_we)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_DIV_STEP;
                end
                S_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cfg_we)
                        state_reg <= S_IDLE;
                    else if (cnt_reg == 5'd31)
                        state_reg <= S_DIV_FIN;
                end
                S_DIV_FIN:    state_reg <= S_IDLE;
                S_DISPATCH:
                begin
                    if (status.func)
                        state_reg <= S_IDLE;
                    else if (!status.any_active)
                        state_reg <= S_EMIT;
                    else if (status.need_update)
                        state_reg <= S_FREQ_MUL;
                    else
                        state_reg <= S_WAVE_MUL;
                end
                S_FREQ_MUL:
                begin
                    if (idx_active)
                        state_reg <= S_FREQ_CLAMP;
                    else if (idx_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_WAVE_MUL;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_FREQ_CLAMP: state_reg <= S_LO_MUL;
                S_LO_MUL:     state_reg <= S_HI_MUL;
                S_HI_MUL:     state_reg <= S_INC_WR;
                S_INC_WR:
                begin
                    if (idx_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_WAVE_MUL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FREQ_MUL;
                    end
                end
                S_WAVE_MUL:
                begin
                    if (idx_active)
                        state_reg <= S_ACC;
                    else if (idx_last)
                        state_reg <= S_GAIN_MUL;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_ACC:
                begin
                    if (idx_last)
                        state_reg <= S_GAIN_MUL;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_WAVE_MUL;
                    end
                end
                S_GAIN_MUL:   state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (status.out_free)
                        state_reg <= S_IDLE;
                end
                default:      state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### design/nco_datapath.sv
module nco_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nco_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nco_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_accept,
    input  logic                              in_func,
    input  logic [nco_pkg::BASE_W-1:0]        in_base_freq,
    input  nco_pkg::cmd_t                     cmd,
    output nco_pkg::status_t                  status,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [nco_pkg::SAMPLE_W-1:0] out_sample
);
    import nco_pkg::*;

    logic [SET_W-1:0]   settings_reg [NUM_OSC];
    logic [PPH_W-1:0]   pph_reg;
    logic [PHASE_W-1:0] phase_reg [NUM_OSC];
    logic [PHASE_W-1:0] inc_reg [NUM_OSC];
    logic [BASE_W-1:0]  cached_reg;
    logic               cache_valid_reg;
    logic [NUM_OSC-1:0] mask_reg;
    logic [16:0]        gain_reg;
    logic               gain_dirty_reg;
    logic [17:0]        sum_reg;
    logic [17:0]        rem_reg;
    logic [16:0]        quot_reg;

    logic               func_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [FREQ_W-1:0]  f_reg;
    logic [45:0]        b_reg;
    logic signed [36:0] acc_reg;
    logic signed [57:0] prod_reg;
    logic               out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [NUM_OSC-1:0] act_c;
    logic [17:0]        sum_c;
    logic [18:0]        trial;
    logic [BASE_W-1:0]  base_clamped;

    logic [SET_W-1:0]   cur_set;
    logic [PHASE_W-1:0] cur_phase;
    logic [15:0]        cur_mix;
    logic signed [3:0]  oct;
    logic [29:0]        f_shift;
    logic [16:0]        det;
    logic signed [17:0] wave;
    logic [30:0]        fq;
    logic [30:0]        fq_clamped;
    logic [66:0]        inc_sum;
    logic signed [57:0] rounded;
    logic signed [26:0] y;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic               out_free;

    logic signed [36:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [57:0] prod;

    function automatic logic [15:0] mix_of(input logic [SET_W-1:0] s);
        return (s[28:13] > MIX_ONE) ? MIX_ONE : s[28:13];
    endfunction

    function automatic logic wave_on(input logic [SET_W-1:0] s);
        return (s[2:0] >= WAVE_SINE) && (s[2:0] <= WAVE_SAW);
    endfunction

    always_comb
    begin
        act_c = '0;
        sum_c = '0;
        for (int i = 0; i < NUM_OSC; i++)
        begin
            if (wave_on(settings_reg[i]) && (mix_of(settings_reg[i]) != 16'd0))
            begin
                act_c[i] = 1'b1;
                sum_c    = sum_c + 18'(mix_of(settings_reg[i]));
            end
        end
    end

    assign trial = {rem_reg, cmd.div_first};

    assign base_clamped = (in_base_freq < BASE_MIN) ? BASE_MIN :
                          (in_base_freq > BASE_MAX) ? BASE_MAX : in_base_freq;

    assign cur_set   = settings_reg[cmd.idx];
    assign cur_phase = phase_reg[cmd.idx];
    assign cur_mix   = mix_of(cur_set);

    // Octave is a signed nibble, held to plus or minus four.
    always_comb
    begin
        oct = signed'(cur_set[6:3]);
        if (oct > 4'sd4)
            oct = 4'sd4;
        else if (oct < -4'sd4)
            oct = -4'sd4;
        if (oct >= 4'sd0)
            f_shift = {4'b0, base_reg, 4'b0} << unsigned'(oct);
        else
            f_shift = {4'b0, base_reg, 4'b0} >> unsigned'(-oct);
    end

    assign det = (32'(cmd.idx) < NUM_DETUNED) ? detune_factor(cur_set[12:7]) : GAIN_ONE;

    always_comb
    begin
        unique case (cur_set[2:0])
            WAVE_SQUARE: wave = cur_phase[31] ? -18'sd32768 : 18'sd32768;
            WAVE_SAW:    wave = 18'sd32768 - signed'({2'b0, cur_phase[31:16]});
            WAVE_SINE, WAVE_TRI:
            begin
                if (cur_phase[31:30] == 2'b00)
                    wave = signed'({1'b0, cur_phase[31:15]});
                else if (cur_phase[31:30] != 2'b11)
                    wave = 18'sd65536 - signed'({1'b0, cur_phase[31:15]});
                else
                    wave = signed'({1'b0, cur_phase[31:15]} ^ 18'h20000);
            end
            default:     wave = 18'sd0;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_FREQ_MUL:
            begin
                mul_a = signed'({7'b0, f_shift});
                mul_b = signed'({4'b0, det});
            end
            OP_LO_MUL:
            begin
                mul_a = signed'({11'b0, f_reg});
                mul_b = signed'({1'b0, pph_reg[19:0]});
            end
            OP_HI_MUL:
            begin
                mul_a = signed'({11'b0, f_reg});
                mul_b = signed'({1'b0, pph_reg[39:20]});
            end
            OP_WAVE_MUL:
            begin
                mul_a = 37'(wave);
                mul_b = signed'({5'b0, cur_mix});
            end
            OP_GAIN_MUL:
            begin
                mul_a = acc_reg;
                mul_b = signed'({4'b0, gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign fq         = prod_reg[46:16];
    assign fq_clamped = (fq < FREQ_MIN) ? FREQ_MIN : (fq > FREQ_MAX) ? FREQ_MAX : fq;
    assign inc_sum    = {1'b0, prod_reg[45:0], 20'b0} + {21'b0, b_reg};

    // Round half up at bit 31, then saturate to Q1.15.
    assign rounded = prod_reg + 58'sd1073741824;
    assign y       = 27'(rounded >>> 31);
    assign y_sat   = (y > 27'sd32767) ? 16'sh7FFF :
                     (y < -27'sd32768) ? -16'sh8000 : 16'(y);

    assign out_free = !out_valid_reg || out_ready;

    assign status.gain_dirty  = gain_dirty_reg;
    assign status.func        = func_reg;
    assign status.any_active  = (mask_reg != '0);
    assign status.need_update = !cache_valid_reg || (base_reg != cached_reg);
    assign status.out_free    = out_free;
    assign status.mask        = mask_reg;

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OSC; i++)
            begin
                settings_reg[i] <= (i == 3) ? SET_RESET_SUB : SET_RESET;
                phase_reg[i]    <= '0;
                inc_reg[i]      <= '0;
            end
            pph_reg         <= PPH_RESET;
            cached_reg      <= '0;
            cache_valid_reg <= 1'b0;
            mask_reg        <= '0;
            gain_reg        <= GAIN_ONE;
            gain_dirty_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (cmd.op)
                OP_DIV_FIN:
                begin
                    gain_reg       <= (sum_reg > 18'(MIX_ONE)) ? quot_reg : GAIN_ONE;
                    gain_dirty_reg <= 1'b0;
                end
                OP_DIV_INIT:  mask_reg <= act_c;
                OP_NOTE_ON:
                begin
                    for (int i = 0; i < NUM_OSC; i++)
                        phase_reg[i] <= '0;
                    cache_valid_reg <= 1'b0;
                end
                OP_CACHE_SET:
                begin
                    cached_reg      <= base_reg;
                    cache_valid_reg <= 1'b1;
                end
                OP_INC_WR:    inc_reg[cmd.idx] <= inc_sum[59:28];
                OP_WAVE_MUL:  phase_reg[cmd.idx] <= cur_phase + inc_reg[cmd.idx];
                OP_EMIT:      out_valid_reg <= 1'b1;
                default:      ;
            endcase

            // A settings write in the last divide cycle must leave the gain dirty.
            if (cfg_we)
            begin
                if (32'(cfg_index) < NUM_OSC)
                begin
                    settings_reg[cfg_index[IDX_W-1:0]] <= cfg_data[SET_W-1:0];
                    gain_dirty_reg  <= 1'b1;
                    cache_valid_reg <= 1'b0;
                end
                else if (cfg_index == REG_PHASE_PER_HZ)
                begin
                    pph_reg         <= cfg_data[PPH_W-1:0];
                    cache_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= in_func;
            base_reg <= base_clamped;
            acc_reg  <= '0;
        end

        unique case (cmd.op)
            OP_DIV_INIT:
            begin
                sum_reg  <= sum_c;
                rem_reg  <= '0;
                quot_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (trial >= {1'b0, sum_reg})
                begin
                    rem_reg  <= 18'(trial - {1'b0, sum_reg});
                    quot_reg <= {quot_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial[17:0];
                    quot_reg <= {quot_reg[15:0], 1'b0};
                end
            end
            OP_FREQ_MUL, OP_LO_MUL, OP_WAVE_MUL, OP_GAIN_MUL: prod_reg <= prod;
            OP_HI_MUL:
            begin
                b_reg    <= prod_reg[45:0];
                prod_reg <= prod;
            end
            OP_FREQ_CLAMP: f_reg <= fq_clamped[FREQ_W-1:0];
            OP_ACC:        acc_reg <= acc_reg + prod_reg[36:0];
            OP_EMIT:       sample_reg <= (mask_reg != '0) ? y_sat : 16'sd0;
            default:       ;
        endcase
    end

endmodule
